### src/seconds_to_calendar_fields_assert.svh
// Assertion macros for the calendar conversion RTL.
`ifndef SECONDS_TO_CALENDAR_FIELDS_ASSERT_SVH
`define SECONDS_TO_CALENDAR_FIELDS_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define SCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/scf_pkg.sv
// Shared types, constants and calendar helper functions for the calendar conversion.
`default_nettype none

package scf_pkg;

    typedef enum logic {
        REG_TZ_OFFSET  = 1'b0,
        REG_DAY_ORIGIN = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [16:0] tz_offset;
        logic [15:0]        day_origin;
    } t_cfg;

    localparam logic signed [16:0] TZ_RESET     = 17'sd0;
    localparam logic [15:0]        ORIGIN_RESET = 16'd25567;

    localparam logic [31:0] HALF_DAY     = 32'd43200;
    localparam logic [31:0] SECS_PER_DAY = 32'd86400;

    localparam logic [63:0] DAY_RECIP_W  = ((64'd1 << 35) + 64'd674) / 64'd675;
    localparam logic [25:0] DAY_RECIP    = DAY_RECIP_W[25:0];
    localparam logic [63:0] HOUR_RECIP_W = ((64'd1 << 21) + 64'd224) / 64'd225;
    localparam logic [13:0] HOUR_RECIP   = HOUR_RECIP_W[13:0];
    localparam logic [63:0] MIN_RECIP_W  = ((64'd1 << 14) + 64'd14) / 64'd15;
    localparam logic [10:0] MIN_RECIP    = MIN_RECIP_W[10:0];
    localparam logic [63:0] YEAR_RECIP_W = ((64'd1 << 26) + 64'd364) / 64'd365;
    localparam logic [17:0] YEAR_RECIP   = YEAR_RECIP_W[17:0];
    localparam logic [63:0] WEEK_RECIP_W = ((64'd1 << 21) + 64'd6) / 64'd7;
    localparam logic [18:0] WEEK_RECIP   = WEEK_RECIP_W[18:0];
    localparam logic [63:0] MON_RECIP_W  = ((64'd1 << 14) + 64'd30) / 64'd31;
    localparam logic [9:0]  MON_RECIP    = MON_RECIP_W[9:0];

    localparam logic [3:0] LAST_MONTH = 4'd11;

    function automatic logic [4:0] div100(input logic [11:0] y);
        div100 = 5'd18 + 5'(y >= 12'd1900) + 5'(y >= 12'd2000) + 5'(y >= 12'd2100)
               + 5'(y >= 12'd2200) + 5'(y >= 12'd2300) + 5'(y >= 12'd2400);
    endfunction

    function automatic logic [2:0] div400(input logic [11:0] y);
        div400 = 3'd4 + 3'(y >= 12'd2000) + 3'(y >= 12'd2400);
    endfunction

    // Valid for years 1899 through 2410, where only these centuries occur.
    function automatic logic is_leap(input logic [11:0] y);
        is_leap = (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100)
               && (y != 12'd2200) && (y != 12'd2300);
    endfunction

    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd365;
        endcase
        cum_days = (leap && (m >= 4'd2)) ? v + 9'd1 : v;
    endfunction

endpackage

`default_nettype wire

### src/scf_daysplit.sv
// Front stages: time zone shift, split into day count and time of day.
`default_nettype none

module scf_daysplit (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [31:0]   i_seconds,
    input  wire scf_pkg::t_cfg i_cfg,
    output logic [16:0]        o_tod,
    output logic [16:0]        o_days
);

    logic [31:0] n_a_dsec;
    logic        n_a_borrow;
    logic [31:0] r_a_dsec;
    logic        r_a_borrow;
    logic [50:0] r_b_prod;
    logic [31:0] r_b_dsec;
    logic        r_b_borrow;
    logic [15:0] w_q;
    logic [32:0] w_qx;
    logic [16:0] w_sum;
    logic [16:0] n_c_tod;
    logic [16:0] n_c_days;
    logic [16:0] r_c_tod;
    logic [16:0] r_c_days;
    logic [31:0] w_tz_ext;

    always_comb begin
        w_tz_ext   = {{15{i_cfg.tz_offset[16]}}, i_cfg.tz_offset};
        n_a_borrow = (i_seconds < scf_pkg::HALF_DAY) && !i_cfg.tz_offset[16]
                     && (i_cfg.tz_offset != 17'sd0);
        n_a_dsec   = i_seconds - w_tz_ext + (n_a_borrow ? scf_pkg::SECS_PER_DAY : 32'd0);
    end

    always_comb begin
        w_q      = r_b_prod[50:35];
        w_qx     = {17'd0, w_q} * {16'd0, scf_pkg::SECS_PER_DAY[16:0]};
        n_c_tod  = r_b_dsec[16:0] - w_qx[16:0];
        w_sum    = {1'b0, w_q} + {1'b0, i_cfg.day_origin};
        n_c_days = (r_b_borrow && (w_sum != 17'd0)) ? w_sum - 17'd1 : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dsec   <= n_a_dsec;
            r_a_borrow <= n_a_borrow;
            r_b_prod   <= {26'd0, r_a_dsec[31:7]} * {25'd0, scf_pkg::DAY_RECIP};
            r_b_dsec   <= r_a_dsec;
            r_b_borrow <= r_a_borrow;
            r_c_tod    <= n_c_tod;
            r_c_days   <= n_c_days;
        end
    end

    assign o_tod  = r_c_tod;
    assign o_days = r_c_days;

endmodule

`default_nettype wire

### src/scf_clock.sv
// Time-of-day stages: hour, minute and second from seconds within the day.
`default_nettype none

module scf_clock (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [16:0] i_tod,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);

    logic [26:0] w_hprod;
    logic [4:0]  r_d_hour;
    logic [16:0] r_d_tod;
    logic [16:0] w_hsec;
    logic [4:0]  r_e_hour;
    logic [11:0] r_e_ms;
    logic [20:0] w_mprod;
    logic [4:0]  r_f_hour;
    logic [5:0]  r_f_min;
    logic [11:0] r_f_ms;
    logic [11:0] w_msec;
    logic [4:0]  r_g_hour;
    logic [5:0]  r_g_min;
    logic [5:0]  r_g_sec;
    logic [4:0]  r_h_hour;
    logic [5:0]  r_h_min;
    logic [5:0]  r_h_sec;

    always_comb begin
        w_hprod = {14'd0, i_tod[16:4]} * {13'd0, scf_pkg::HOUR_RECIP};
        w_hsec  = {12'd0, r_d_hour} * 17'd3600;
        w_mprod = {11'd0, r_e_ms[11:2]} * {10'd0, scf_pkg::MIN_RECIP};
        w_msec  = r_f_ms - {6'd0, r_f_min} * 12'd60;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_hour <= w_hprod[25:21];
            r_d_tod  <= i_tod;
            r_e_hour <= r_d_hour;
            r_e_ms   <= 12'(r_d_tod - w_hsec);
            r_f_hour <= r_e_hour;
            r_f_min  <= w_mprod[19:14];
            r_f_ms   <= r_e_ms;
            r_g_hour <= r_f_hour;
            r_g_min  <= r_f_min;
            r_g_sec  <= w_msec[5:0];
            r_h_hour <= r_g_hour;
            r_h_min  <= r_g_min;
            r_h_sec  <= r_g_sec;
        end
    end

    assign o_hour   = r_h_hour;
    assign o_minute = r_h_min;
    assign o_second = r_h_sec;

endmodule

`default_nettype wire

### src/scf_date.sv
// Date stages: year, day of year, month, day of month and weekday from a day count.
`default_nettype none

module scf_date (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [16:0] i_days,
    output logic [8:0]       o_years,
    output logic [8:0]       o_yday,
    output logic [3:0]       o_month,
    output logic [4:0]       o_mday,
    output logic [2:0]       o_wday
);

    logic [17:0] w_wx;
    logic [34:0] w_yprod;
    logic [36:0] w_wprod;
    logic [8:0]  r_d_ys;
    logic [15:0] r_d_wq;
    logic [16:0] r_d_days;

    logic [11:0] w_y;
    logic [17:0] w_dby;
    logic [17:0] w_wx_d;
    logic [17:0] w_w7;
    logic [8:0]  r_e_ys;
    logic [17:0] r_e_dby;
    logic        r_e_l0;
    logic        r_e_l1;
    logic [16:0] r_e_days;
    logic [2:0]  r_e_wday;

    logic [18:0] w_diff;
    logic [18:0] w_fix;
    logic [8:0]  r_f_ys;
    logic [8:0]  r_f_yday;
    logic        r_f_leap;
    logic [2:0]  r_f_wday;

    logic [18:0] w_mprod;
    logic [3:0]  w_mon0;
    logic [8:0]  r_g_ys;
    logic [8:0]  r_g_yday;
    logic        r_g_leap;
    logic [2:0]  r_g_wday;
    logic [3:0]  r_g_mon;

    logic [3:0]  w_mon_up;
    logic [8:0]  w_next;
    logic        w_step;
    logic [8:0]  w_dom_a;
    logic [8:0]  w_dom_b;
    logic [8:0]  r_h_ys;
    logic [8:0]  r_h_yday;
    logic [3:0]  r_h_mon;
    logic [4:0]  r_h_mday;
    logic [2:0]  r_h_wday;

    always_comb begin
        w_wx    = {1'b0, i_days} + 18'd1;
        w_yprod = {18'd0, i_days} * {17'd0, scf_pkg::YEAR_RECIP};
        w_wprod = {19'd0, w_wx} * {18'd0, scf_pkg::WEEK_RECIP};
    end

    always_comb begin
        w_y    = {3'd0, r_d_ys} + 12'd1899;
        w_dby  = {8'd0, w_y[11:2]} - {13'd0, scf_pkg::div100(w_y)}
               + {15'd0, scf_pkg::div400(w_y)} - 18'd460 + {9'd0, r_d_ys} * 18'd365;
        w_wx_d = {1'b0, r_d_days} + 18'd1;
        w_w7   = {2'd0, r_d_wq} * 18'd7;
    end

    // The estimate from days / 365 is at most one year too high.
    always_comb begin
        w_diff = {2'd0, r_e_days} - {1'b0, r_e_dby};
        w_fix  = w_diff + 19'd365 + {18'd0, r_e_l0};
    end

    always_comb begin
        w_mprod = {10'd0, r_f_yday} * {9'd0, scf_pkg::MON_RECIP};
        w_mon0  = (w_mprod[17:14] > scf_pkg::LAST_MONTH) ? scf_pkg::LAST_MONTH
                                                         : w_mprod[17:14];
    end

    always_comb begin
        w_mon_up = r_g_mon + 4'd1;
        w_next   = scf_pkg::cum_days(r_g_leap, w_mon_up);
        w_step   = (r_g_yday >= w_next) && (r_g_mon < scf_pkg::LAST_MONTH);
        w_dom_a  = r_g_yday - scf_pkg::cum_days(r_g_leap, r_g_mon) + 9'd1;
        w_dom_b  = r_g_yday - w_next + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ys   <= w_yprod[34:26];
            r_d_wq   <= w_wprod[36:21];
            r_d_days <= i_days;

            r_e_ys   <= r_d_ys;
            r_e_dby  <= w_dby;
            r_e_l0   <= scf_pkg::is_leap(w_y);
            r_e_l1   <= scf_pkg::is_leap(w_y + 12'd1);
            r_e_days <= r_d_days;
            r_e_wday <= 3'(w_wx_d - w_w7);

            if (w_diff[18]) begin
                r_f_yday <= w_fix[8:0];
                r_f_ys   <= r_e_ys - 9'd1;
                r_f_leap <= r_e_l0;
            end else begin
                r_f_yday <= w_diff[8:0];
                r_f_ys   <= r_e_ys;
                r_f_leap <= r_e_l1;
            end
            r_f_wday <= r_e_wday;

            r_g_ys   <= r_f_ys;
            r_g_yday <= r_f_yday;
            r_g_leap <= r_f_leap;
            r_g_wday <= r_f_wday;
            r_g_mon  <= w_mon0;

            r_h_ys   <= r_g_ys;
            r_h_yday <= r_g_yday;
            r_h_mon  <= w_step ? w_mon_up : r_g_mon;
            r_h_mday <= w_step ? w_dom_b[4:0] : w_dom_a[4:0];
            r_h_wday <= r_g_wday;
        end
    end

    assign o_years = r_h_ys;
    assign o_yday  = r_h_yday;
    assign o_month = r_h_mon;
    assign o_mday  = r_h_mday;
    assign o_wday  = r_h_wday;

endmodule

`default_nettype wire

### src/seconds_to_calendar_fields.sv
// Top level: converts a seconds count into calendar fields with an APB register port.
//
// A word on the input channel (i_in_valid / o_in_ready) carries one seconds count.
// Each accepted word yields exactly one word on the output channel
// (o_out_valid / i_out_ready) with hour, minute, second, years since 1900,
// day of year, month, day of month and weekday.
// The datapath is an eight-stage pipeline, and one word per cycle can flow in and
// out while the receiver does not stall.
// The last stage is the output register. When the receiver stalls with a word
// waiting, the whole pipeline holds and o_in_ready falls; nothing is lost.
// Reset empties the pipeline and sets the time zone offset to 0 and the day
// origin to serial day 25567 (1970-01-01).
// The time zone offset lives at byte address 0 and the day origin at 4.
// Write them only while the pipeline is empty.
`default_nettype none

`include "seconds_to_calendar_fields_assert.svh"

module seconds_to_calendar_fields (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_seconds,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic [8:0]       o_years_since_1900,
    output logic [8:0]       o_day_of_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day_of_month,
    output logic [2:0]       o_weekday
);

    scf_pkg::t_cfg     r_cfg;
    scf_pkg::t_reg_idx w_idx;
    logic [7:0]        r_valid;
    logic              w_adv;
    logic [16:0]       w_tod;
    logic [16:0]       w_days;
    logic              w_time_ok;
    logic              w_date_ok;
    logic              w_wday_ok;
    logic              w_to_out;

    assign pready = 1'b1;
    assign w_idx  = scf_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (w_idx)
            scf_pkg::REG_TZ_OFFSET:  prdata = {{15{r_cfg.tz_offset[16]}}, r_cfg.tz_offset};
            scf_pkg::REG_DAY_ORIGIN: prdata = {16'd0, r_cfg.day_origin};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tz_offset  <= scf_pkg::TZ_RESET;
            r_cfg.day_origin <= scf_pkg::ORIGIN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                scf_pkg::REG_TZ_OFFSET:  r_cfg.tz_offset  <= pwdata[16:0];
                scf_pkg::REG_DAY_ORIGIN: r_cfg.day_origin <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_adv      = !r_valid[7] || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 8'd0;
        end else if (w_adv) begin
            r_valid <= {r_valid[6:0], i_in_valid};
        end
    end

    assign o_out_valid = r_valid[7];

    scf_daysplit u_daysplit (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_seconds (i_seconds),
        .i_cfg     (r_cfg),
        .o_tod     (w_tod),
        .o_days    (w_days)
    );

    scf_clock u_clock (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_tod    (w_tod),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

    scf_date u_date (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_days  (w_days),
        .o_years (o_years_since_1900),
        .o_yday  (o_day_of_year),
        .o_month (o_month),
        .o_mday  (o_day_of_month),
        .o_wday  (o_weekday)
    );

    assign w_time_ok = (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60);
    assign w_date_ok = (o_month < 4'd12) && (o_day_of_month != 5'd0)
                       && (o_day_of_year < 9'd366);
    assign w_wday_ok = o_weekday < 3'd7;
    assign w_to_out  = r_valid[6] && w_adv;

    `SCF_ASSERT_NOW(a_time_range, i_clk, i_rst_n, o_out_valid, w_time_ok, "bad time of day")
    `SCF_ASSERT_NOW(a_date_range, i_clk, i_rst_n, o_out_valid, w_date_ok, "bad date field")
    `SCF_ASSERT_NOW(a_wday_range, i_clk, i_rst_n, o_out_valid, w_wday_ok, "bad weekday")
    `SCF_ASSERT_NEXT(a_last_stage, i_clk, i_rst_n, w_to_out, o_out_valid, "word lost")

endmodule

`default_nettype wire

### tb/seconds_to_calendar_fields_tb.sv
// Self-checking testbench for the seconds to calendar fields converter.
`timescale 1ns / 100ps

module seconds_to_calendar_fields_tb;

    typedef struct {
        bit [4:0] hour;
        bit [5:0] minute;
        bit [5:0] second;
        bit [8:0] years;
        bit [8:0] yday;
        bit [3:0] month;
        bit [4:0] mday;
        bit [2:0] wday;
    } t_calendar;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int ITEMS_PER_SET  = 220;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_seconds = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [8:0]  o_years_since_1900;
    logic [8:0]  o_day_of_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [2:0]  o_weekday;

    bit signed [16:0] tz_offset_model = scf_pkg::TZ_RESET;
    bit [15:0]        day_origin_model = scf_pkg::ORIGIN_RESET;
    bit [31:0]        pending_seconds[$];
    t_calendar        expected_dates[$];
    int               mismatches = 0;
    int               send_gap = 0;
    int               recv_gap = 0;
    bit               steady = 1'b0;
    int               quiet_cycles = 0;

    int cum_normal[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
    int cum_leap[13]   = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};

    seconds_to_calendar_fields DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit leap_year(int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int year_start_day(int unsigned ys);
        int unsigned y;
        y = ys + 1899;
        return int'((y >> 2) - y / 100 + y / 400 - 460 + 365 * ys);
    endfunction

    function automatic t_calendar convert_seconds(bit [31:0] secs);
        t_calendar   c;
        bit [31:0]   tzu;
        bit [31:0]   dsec;
        bit [31:0]   days;
        int unsigned ys;
        int unsigned tod;
        int          yday;
        int          mon;
        bit          leap;
        tzu = {{15{tz_offset_model[16]}}, tz_offset_model};
        if (secs >= scf_pkg::HALF_DAY || tz_offset_model <= 0) begin
            dsec = secs - tzu;
            days = dsec / scf_pkg::SECS_PER_DAY + day_origin_model;
        end else begin
            dsec = secs + scf_pkg::SECS_PER_DAY - tzu;
            days = dsec / scf_pkg::SECS_PER_DAY + day_origin_model;
            if (days > 0) days = days - 1;
        end
        tod = dsec % scf_pkg::SECS_PER_DAY;
        ys = days / 365;
        yday = int'(days) - year_start_day(ys);
        while (yday < 0 && ys > 0) begin
            yday += 365 + (leap_year(ys + 1899) ? 1 : 0);
            ys -= 1;
        end
        if (yday < 0) yday = 0;
        leap = leap_year(ys + 1900);
        mon = yday / 31;
        if (mon > 11) mon = 11;
        if (mon < 11 && yday >= (leap ? cum_leap[mon + 1] : cum_normal[mon + 1])) mon += 1;
        c.hour = 5'(tod / 3600);
        c.minute = 6'(tod % 3600 / 60);
        c.second = 6'(tod % 60);
        c.years = 9'(ys);
        c.yday = 9'(yday);
        c.month = 4'(mon);
        c.mday = 5'(yday - (leap ? cum_leap[mon] : cum_normal[mon]) + 1);
        c.wday = 3'((days + 1) % 7);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        bit load;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            load = 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_seconds.size() > 0) begin
                load = 1'b1;
                i_seconds <= pending_seconds.pop_front();
                send_gap <= pick_gap();
            end
            i_in_valid <= load;
        end
    end

    task automatic report(string field, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("Mismatch in %s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_calendar want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    report("unexpected word", 0, 1);
                end else begin
                    want = expected_dates.pop_front();
                    if (o_hour !== want.hour) report("hour", want.hour, o_hour);
                    if (o_minute !== want.minute) report("minute", want.minute, o_minute);
                    if (o_second !== want.second) report("second", want.second, o_second);
                    if (o_years_since_1900 !== want.years)
                        report("years_since_1900", want.years, o_years_since_1900);
                    if (o_day_of_year !== want.yday)
                        report("day_of_year", want.yday, o_day_of_year);
                    if (o_month !== want.month) report("month", want.month, o_month);
                    if (o_day_of_month !== want.mday)
                        report("day_of_month", want.mday, o_day_of_month);
                    if (o_weekday !== want.wday) report("weekday", want.wday, o_weekday);
                end
            end
            if (i_in_valid && o_in_ready) expected_dates.push_back(convert_seconds(i_seconds));
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready) recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || psel || (pending_seconds.size() == 0 && expected_dates.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_seconds.size() > 0 || expected_dates.size() > 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    task automatic write_register(scf_pkg::t_reg_idx idx, bit [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == scf_pkg::REG_TZ_OFFSET) tz_offset_model = value[16:0];
        else day_origin_model = value[15:0];
    endtask

    task automatic queue_word_set(int count);
        int r;
        pending_seconds.push_back(32'd0);
        pending_seconds.push_back(32'd1);
        pending_seconds.push_back(32'd43199);
        pending_seconds.push_back(32'd43200);
        pending_seconds.push_back(32'd86399);
        pending_seconds.push_back(32'd86400);
        pending_seconds.push_back(32'd951782400);
        pending_seconds.push_back(32'd951868800);
        pending_seconds.push_back(32'd4107456000);
        pending_seconds.push_back(32'hAAAA_AAAA);
        pending_seconds.push_back(32'h5555_5555);
        pending_seconds.push_back(32'hFFFF_FFFE);
        pending_seconds.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 9);
            if (r < 5) pending_seconds.push_back($urandom);
            else if (r < 8) pending_seconds.push_back($urandom_range(0, 172800));
            else pending_seconds.push_back(32'hFFFF_FFFF - $urandom_range(0, 172800));
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin
        bit [31:0] tz_set[8];
        bit [31:0] origin_set[8];
        tz_set = '{32'd0, 32'd43200, -32'sd43200, 32'h0000_FFFF, 32'h0001_0000,
                   32'd1, 32'd3600, 32'd0};
        origin_set = '{32'd25567, 32'd1, 32'd65535, 32'd0, 32'd0, 32'd1, 32'd36524, 32'd0};
        tz_set[7] = $urandom_range(0, 86400) - 43200;
        origin_set[7] = $urandom_range(1, 65535);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            if (p > 0) begin
                write_register(scf_pkg::REG_TZ_OFFSET, {15'd0, tz_set[p][16:0]});
                write_register(scf_pkg::REG_DAY_ORIGIN, origin_set[p]);
            end
            steady = (p == 2);
            queue_word_set(ITEMS_PER_SET);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### seconds_to_calendar_fields.f
+incdir+src
src/scf_pkg.sv
src/scf_daysplit.sv
src/scf_clock.sv
src/scf_date.sv
src/seconds_to_calendar_fields.sv
tb/seconds_to_calendar_fields_tb.sv
